// File: hw/rtl/atg_pkg.sv
// ----------------------------------------------------------------------------
// atg_pkg
// Shared types, constants and command/status structs of the throttle gate.
// ----------------------------------------------------------------------------
package atg_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_WIDTH   = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int HOLD_W      = 32;
    localparam int MODE_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [1:0] {
        OP_QUEUE   = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTART = 2'd2,
        OP_CLEAR   = 2'd3
    } t_opcode;

    typedef enum logic [MODE_W-1:0] {
        MODE_OPEN   = 3'd0,
        MODE_CLOSED = 3'd1,
        MODE_PAUSE  = 3'd2,
        MODE_UNTIL  = 3'd3,
        MODE_LIMIT  = 3'd4,
        MODE_DELAY  = 3'd5
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_IMM  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_EVAL,
        ST_REL_RD,
        ST_REL_LD,
        ST_STAT
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic do_pre;
        logic do_eval;
        logic pop_load;
        logic stat_load;
    } t_dp_cmd;

    typedef struct packed {
        logic rel_req;
        logic rel_more;
        logic out_free;
    } t_dp_sts;

endpackage

// File: hw/rtl/atg_ctrl.sv
// ----------------------------------------------------------------------------
// atg_ctrl
// Sequencer: accept, pre-step, mode evaluation, then release or status beat.
// ----------------------------------------------------------------------------
module atg_ctrl
    import atg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_PRE;
                end
            end
            ST_PRE:  n_state = ST_EVAL;
            ST_EVAL: begin
                n_state = i_sts.rel_req ? ST_REL_RD : ST_STAT;
            end
            ST_REL_RD: n_state = ST_REL_LD;
            ST_REL_LD: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.rel_more ? ST_REL_RD : ST_IDLE;
                end
            end
            ST_STAT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready     = i_rst_n;
                o_cmd.latch_in = i_in_valid && i_rst_n;
            end
            ST_PRE:    o_cmd.do_pre = 1'b1;
            ST_EVAL:   o_cmd.do_eval = 1'b1;
            ST_REL_RD: o_cmd = '0;
            ST_REL_LD: o_cmd.pop_load = i_sts.out_free;
            ST_STAT:   o_cmd.stat_load = i_sts.out_free;
            default:   o_cmd = '0;
        endcase
    end

endmodule

// File: hw/rtl/atg_dp.sv
// ----------------------------------------------------------------------------
// atg_dp
// Datapath: config registers, mode/timer state, tag FIFO and output register.
// ----------------------------------------------------------------------------
module atg_dp
    import atg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_opcode,
    input  logic [TAG_WIDTH-1:0]  i_action_tag,
    input  logic                  i_replace_pending,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_released_valid,
    output logic [TAG_WIDTH-1:0]  o_released_tag,
    output logic                  o_last,
    output logic [MODE_W-1:0]     o_current_mode,
    output logic                  o_timer_running,
    output logic [CNT_W-1:0]      o_pending_count,
    output logic                  o_dropped
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

    logic [MODE_W-1:0]    r_start_mode;
    logic [HOLD_W-1:0]    r_hold;
    logic                 r_imm;

    t_opcode              r_op;
    logic [TAG_WIDTH-1:0] r_tag;
    logic                 r_repl;

    t_mode                r_mode;
    logic                 r_run;
    logic [HOLD_W-1:0]    r_elapsed;
    logic [PTR_W-1:0]     r_head;
    logic [CNT_W-1:0]     r_count;
    logic                 r_drop;
    logic                 r_fq;
    logic                 r_do_eval;
    logic                 r_rel_all;

    logic [TAG_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0] r_rd_tag;

    logic                 r_out_valid;
    logic                 r_out_rel;
    logic [TAG_WIDTH-1:0] r_out_tag;
    logic                 r_out_last;
    logic [MODE_W-1:0]    r_out_mode;
    logic                 r_out_run;
    logic [CNT_W-1:0]     r_out_cnt;
    logic                 r_out_drop;

    // pre-step queue path
    logic [CNT_W-1:0]     q_cnt;
    logic [PTR_W-1:0]     q_head;
    logic [CNT_W:0]       q_sum;
    logic [PTR_W-1:0]     q_pos;
    logic                 q_full;
    logic                 mem_we;
    logic                 rs_valid;
    logic                 rs_timer;

    // evaluation
    logic                 ev_exp;
    t_mode                ev_mode;
    logic                 ev_stop;
    logic                 ev_start;
    logic                 ev_one;
    logic                 ev_all;

    logic                 out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_mode <= '0;
            r_hold       <= '0;
            r_imm        <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_MODE: r_start_mode <= i_cfg_data[MODE_W-1:0];
                CFG_HOLD_TICKS: r_hold       <= i_cfg_data[HOLD_W-1:0];
                CFG_START_IMM:  r_imm        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op   <= t_opcode'(i_opcode);
            r_tag  <= i_action_tag;
            r_repl <= i_replace_pending;
        end
    end

    always_comb begin
        q_cnt  = r_repl ? '0 : r_count;
        q_head = r_repl ? '0 : r_head;
        q_full = (q_cnt == DEPTH_C);
        q_sum  = {1'b0, (CNT_W)'(q_head)} + {1'b0, q_cnt};
        if (q_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            q_sum = q_sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        q_pos    = q_sum[PTR_W-1:0];
        mem_we   = i_cmd.do_pre && (r_op == OP_QUEUE) && !q_full;
        rs_valid = (r_start_mode <= MODE_W'(MODE_DELAY));
        rs_timer = ((r_start_mode == MODE_W'(MODE_PAUSE)) ||
                    (r_start_mode == MODE_W'(MODE_UNTIL))) && r_imm;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[q_pos] <= r_tag;
        end
        r_rd_tag <= r_mem[r_head];
    end

    always_comb begin
        ev_exp   = (r_elapsed >= r_hold);
        ev_mode  = r_mode;
        ev_stop  = 1'b0;
        ev_start = 1'b0;
        ev_one   = 1'b0;
        ev_all   = 1'b0;
        case (r_mode)
            MODE_OPEN: ev_all = 1'b1;
            MODE_PAUSE: begin
                if (r_run && ev_exp) begin
                    ev_stop = 1'b1;
                    ev_mode = MODE_OPEN;
                    ev_all  = 1'b1;
                end else if (!r_run && r_fq) begin
                    ev_start = 1'b1;
                end
            end
            MODE_UNTIL: begin
                if (r_run && ev_exp) begin
                    ev_stop = 1'b1;
                    ev_mode = MODE_CLOSED;
                end else begin
                    ev_start = !r_run && r_fq;
                    ev_all   = 1'b1;
                end
            end
            MODE_LIMIT: begin
                if (!r_run || ev_exp) begin
                    ev_start = (r_count != '0);
                    ev_one   = 1'b1;
                end
            end
            MODE_DELAY: begin
                if (r_run && ev_exp) begin
                    ev_start = (r_count != '0);
                    ev_one   = 1'b1;
                end else if (!r_run || r_fq) begin
                    ev_start = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_OPEN;
            r_run     <= 1'b0;
            r_elapsed <= '0;
            r_head    <= '0;
            r_count   <= '0;
            r_drop    <= 1'b0;
            r_fq      <= 1'b0;
            r_do_eval <= 1'b0;
            r_rel_all <= 1'b0;
        end else begin
            if (i_cmd.do_pre) begin
                r_drop    <= 1'b0;
                r_fq      <= 1'b0;
                r_do_eval <= 1'b0;
                case (r_op)
                    OP_QUEUE: begin
                        r_head    <= q_head;
                        r_fq      <= 1'b1;
                        r_do_eval <= 1'b1;
                        if (q_full) begin
                            r_count <= q_cnt;
                            r_drop  <= 1'b1;
                        end else begin
                            r_count <= q_cnt + CNT_W'(1);
                        end
                    end
                    OP_TICK: begin
                        if (r_run && (r_elapsed != '1)) begin
                            r_elapsed <= r_elapsed + HOLD_W'(1);
                        end
                        r_do_eval <= (r_count != '0);
                    end
                    OP_RESTART: begin
                        if (rs_valid) begin
                            r_run     <= rs_timer;
                            if (rs_timer) begin
                                r_elapsed <= '0;
                            end
                            r_mode    <= t_mode'(r_start_mode);
                            r_do_eval <= 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        r_count <= '0;
                        r_head  <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.do_eval) begin
                r_rel_all <= ev_all;
                if (r_do_eval) begin
                    r_mode <= ev_mode;
                    if (ev_start) begin
                        r_run     <= 1'b1;
                        r_elapsed <= '0;
                    end else if (ev_stop) begin
                        r_run <= 1'b0;
                    end
                end
            end
            if (i_cmd.pop_load) begin
                r_head  <= (r_head == LAST_P) ? '0 : r_head + PTR_W'(1);
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pop_load || i_cmd.stat_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_load) begin
            r_out_rel  <= 1'b1;
            r_out_tag  <= r_rd_tag;
            r_out_last <= !(r_rel_all && (r_count != CNT_W'(1)));
            r_out_mode <= r_mode;
            r_out_run  <= r_run;
            r_out_cnt  <= r_count - CNT_W'(1);
            r_out_drop <= r_drop;
        end else if (i_cmd.stat_load) begin
            r_out_rel  <= 1'b0;
            r_out_tag  <= '0;
            r_out_last <= 1'b1;
            r_out_mode <= r_mode;
            r_out_run  <= r_run;
            r_out_cnt  <= r_count;
            r_out_drop <= r_drop;
        end
    end

    assign o_sts.rel_req  = r_do_eval && (ev_one || ev_all) && (r_count != '0);
    assign o_sts.rel_more = r_rel_all && (r_count != CNT_W'(1));
    assign o_sts.out_free = out_free;

    assign o_out_valid      = r_out_valid;
    assign o_released_valid = r_out_rel;
    assign o_released_tag   = r_out_tag;
    assign o_last           = r_out_last;
    assign o_current_mode   = r_out_mode;
    assign o_timer_running  = r_out_run;
    assign o_pending_count  = r_out_cnt;
    assign o_dropped        = r_out_drop;

endmodule

// File: hw/rtl/action_throttle_gate.sv
// ----------------------------------------------------------------------------
// action_throttle_gate
// Tag FIFO released by mode: open, closed, pause, until, limit, delay.
//
// Input channel (i_in_valid/o_in_ready) takes one op per beat: queue a tag,
// tick the timer, restart with the configured mode, or clear the queue.
// Output channel (o_out_valid/i_out_ready) returns either one status beat
// or one beat per released tag in FIFO order, o_last on the final one.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 start mode, 1 hold ticks, 2 start immediately); write only when idle.
// Sequence: an op is accepted, then a pre-step and a mode evaluation
// follow; a status beat is then loaded once the output register is free.
// Each release is a FIFO read followed by an output load, since the FIFO
// has a single read port. A new op is taken only after the last beat loads.
// The output is a register: the next op is accepted while a beat waits.
// When the receiver stalls, the sequencer holds until the output frees.
// Reset (synchronous, active low) clears mode, timer, queue and config;
// FIFO contents are not cleared.
// ----------------------------------------------------------------------------
module action_throttle_gate
    import atg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_opcode,
    input  logic [TAG_WIDTH-1:0]  i_action_tag,
    input  logic                  i_replace_pending,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_released_valid,
    output logic [TAG_WIDTH-1:0]  o_released_tag,
    output logic                  o_last,
    output logic [MODE_W-1:0]     o_current_mode,
    output logic                  o_timer_running,
    output logic [CNT_W-1:0]      o_pending_count,
    output logic                  o_dropped
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    atg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    atg_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_opcode),
        .i_action_tag      (i_action_tag),
        .i_replace_pending (i_replace_pending),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_released_valid  (o_released_valid),
        .o_released_tag    (o_released_tag),
        .o_last            (o_last),
        .o_current_mode    (o_current_mode),
        .o_timer_running   (o_timer_running),
        .o_pending_count   (o_pending_count),
        .o_dropped         (o_dropped)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted twice in a row");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_released_valid |-> o_last && (o_released_tag == '0))
        else $error("status beat not marked last");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pending_count <= CNT_W'(QUEUE_DEPTH)))
        else $error("pending count out of range");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.latch_in, cmd.do_pre, cmd.do_eval, cmd.pop_load, cmd.stat_load}))
        else $error("datapath commands overlap");

endmodule
